/* rtl/core/lmns_pkg.sv */
// Package: heading, action, situation and request codes plus heading rotation tables.
package lmns_pkg;

  // Absolute headings; an action code reuses the same values as a relative rotation.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ABOUT = 2'd1;
  localparam logic [1:0] ACT_LEFT  = 2'd2;
  localparam logic [1:0] ACT_RIGHT = 2'd3;

  localparam logic [1:0] SIT_PLAIN = 2'd0;
  localparam logic [1:0] SIT_CROSS = 2'd1;
  localparam logic [1:0] SIT_TURN  = 2'd2;
  localparam logic [1:0] SIT_DEAD  = 2'd3;

  localparam logic [1:0] REQ_STEP    = 2'd0;
  localparam logic [1:0] REQ_APPEND  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_START_X = 2'd1;
  localparam logic [1:0] CFG_START_Y = 2'd2;
  localparam logic [1:0] CFG_FACING  = 2'd3;

  // Sensor bit positions
  localparam int SNS_AHEAD  = 0;
  localparam int SNS_BEHIND = 1;
  localparam int SNS_LEFT   = 2;
  localparam int SNS_RIGHT  = 3;

  localparam logic [1:0] TURN_ABOUT [4] = '{DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};
  localparam logic [1:0] TURN_LEFT  [4] = '{DIR_LEFT, DIR_RIGHT, DIR_DOWN, DIR_UP};
  localparam logic [1:0] TURN_RIGHT [4] = '{DIR_RIGHT, DIR_LEFT, DIR_UP, DIR_DOWN};

  function automatic logic [1:0] rotate_heading(input logic [1:0] h, input logic [1:0] act);
    logic [1:0] r;
    case (act)
      ACT_ABOUT: r = TURN_ABOUT[h];
      ACT_LEFT:  r = TURN_LEFT[h];
      ACT_RIGHT: r = TURN_RIGHT[h];
      default:   r = h;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/line_maze_navigation_step.sv */
// Top level: left-hand-rule line maze navigation step with path recorder and replay.
//
// One request enters per cycle: a transfer on the in_ channel is held in an input
// register, and from that register it is classified, the heading rotated, the position
// moved and the path store accessed, all in one pass; its result lands in the output
// register and is offered on out_ from there, so throughput is one request per cycle
// as long as out_tready stays high and the result register drains. When the
// result register is full and not taken, the input register holds its request and
// in_tready drops. Requests are in_tuser = req_type (0 sensor step, 1 append path
// entry, 2 restart); in_tdata carries sensors and path_entry. The path store is a
// PATH_DEPTH x 2 memory with one write and one registered read port; the read port
// keeps the next replay entry prefetched (with write forwarding), so replay also runs
// at one step per cycle. The store is not cleared after reset: only entries below the
// fill count are ever replayed. Configuration registers (0 discovery_mode, 1 start_x,
// 2 start_y, 3 start_facing) are written through cfg_we/cfg_index/cfg_data and must
// only change while no request is in flight.
module line_maze_navigation_step
  import lmns_pkg::*;
#(
  parameter int PATH_DEPTH = 128,
  parameter int COORD_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  // request channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // fields from bit 0: sensors[3:0], path_entry[5:4], zero fill
  input  logic [7:0]           in_tdata,
  // fields from bit 0: req_type[1:0]
  input  logic [1:0]           in_tuser,
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // fields from bit 0: pos_x, pos_y (COORD_BITS each), heading[2], action[2],
  // situation[2], destination[1], path_length[8], path_overflow[1],
  // replay_exhausted[1], zero fill to whole bytes
  output logic [((2*COORD_BITS+17+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W = ((2*COORD_BITS+17+7)/8)*8;
  localparam int AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW    = $clog2(PATH_DEPTH+1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

  // configuration registers
  logic                  mode_r;
  logic [7:0]            start_x_r, start_y_r;
  logic [1:0]            start_facing_r;

  // navigation state
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [1:0]            hd_r, hd_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ridx_r, ridx_nxt;
  logic                  ovf_r, ovf_nxt;

  // input register
  logic                  s1_valid_r;
  logic [1:0]            s1_req_r;
  logic [3:0]            s1_sns_r;
  logic [1:0]            s1_entry_r;

  // result register
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  // path store and prefetched replay entry
  logic [1:0]            mem [PATH_DEPTH];
  logic [1:0]            head_r;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [1:0]            wr_data;

  logic                  s1_fire;
  logic [1:0]            act, sit;
  logic                  dest, exh;
  logic                  rec;
  logic [1:0]            rec_code;
  logic [2:0]            active;
  logic                  ahead, behind, lft, rgt;

  // Advance the input register whenever the result register is free or being drained.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  assign ahead  = s1_sns_r[SNS_AHEAD];
  assign behind = s1_sns_r[SNS_BEHIND];
  assign lft    = s1_sns_r[SNS_LEFT];
  assign rgt    = s1_sns_r[SNS_RIGHT];
  assign active = 3'(ahead) + 3'(behind) + 3'(lft) + 3'(rgt);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    hd_nxt   = hd_r;
    cnt_nxt  = cnt_r;
    ridx_nxt = ridx_r;
    ovf_nxt  = ovf_r;
    act      = ACT_NONE;
    sit      = SIT_PLAIN;
    dest     = 1'b0;
    exh      = 1'b0;
    rec      = 1'b0;
    rec_code = s1_entry_r;
    wr_en    = 1'b0;

    if (s1_fire) begin
      case (s1_req_r)
        REQ_STEP: begin
          dest = (active == 3'd4);
          if (active >= 3'd3) begin
            sit = SIT_CROSS;
            if (mode_r) begin
              // left-hand rule: left, else straight, else right
              if (lft)        act = ACT_LEFT;
              else if (ahead) act = ACT_NONE;
              else if (rgt)   act = ACT_RIGHT;
              rec      = 1'b1;
              rec_code = act;
            end else if (ridx_r < cnt_r) begin
              act      = head_r;
              ridx_nxt = ridx_r + CW'(1);
            end else begin
              exh = 1'b1;
            end
          end else if (behind && !ahead && (lft || rgt)) begin
            sit = SIT_TURN;
            act = lft ? ACT_LEFT : ACT_RIGHT;
          end else if (behind && !ahead) begin
            sit      = SIT_DEAD;
            act      = ACT_ABOUT;
            rec      = mode_r;
            rec_code = ACT_ABOUT;
          end
          hd_nxt = rotate_heading(hd_r, act);
          case (hd_nxt)
            DIR_UP:   y_nxt = y_r - COORD_BITS'(1);
            DIR_DOWN: y_nxt = y_r + COORD_BITS'(1);
            DIR_LEFT: x_nxt = x_r - COORD_BITS'(1);
            default:  x_nxt = x_r + COORD_BITS'(1);
          endcase
        end
        REQ_APPEND: begin
          rec = 1'b1;
        end
        REQ_RESTART: begin
          x_nxt    = COORD_BITS'(start_x_r);
          y_nxt    = COORD_BITS'(start_y_r);
          hd_nxt   = start_facing_r;
          ridx_nxt = '0;
          if (mode_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
        default: ;
      endcase

      // Drop the record and flag overflow once the store is full.
      if (rec) begin
        if (cnt_r < DEPTH_C) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    out_data_nxt = OUT_W'({exh, ovf_nxt, 8'(cnt_nxt), dest, sit, act, hd_nxt, y_nxt, x_nxt});
  end

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = rec_code;
  // Prefetch the entry the next replay intersection will use.
  assign rd_addr = ridx_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (wr_en && wr_addr == rd_addr) head_r <= wr_data;
    else                             head_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= 1'b1;
      start_x_r      <= '0;
      start_y_r      <= '0;
      start_facing_r <= DIR_RIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    mode_r         <= cfg_data[0];
        CFG_START_X: start_x_r      <= cfg_data;
        CFG_START_Y: start_y_r      <= cfg_data;
        CFG_FACING:  start_facing_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      hd_r   <= DIR_RIGHT;
      cnt_r  <= '0;
      ridx_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      hd_r   <= hd_nxt;
      cnt_r  <= cnt_nxt;
      ridx_r <= ridx_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Input register: load on every transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r   <= in_tuser;
      s1_sns_r   <= in_tdata[3:0];
      s1_entry_r <= in_tdata[5:4];
    end
  end

  // Result register: fill on fire, drain on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("path store fill count beyond depth");

  a_ridx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ridx_r <= cnt_r)
    else $error("replay index passed fill count");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == DEPTH_C))
    else $error("overflow flagged while store not full");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result lost after fire");

endmodule

/* verif/lmns_checker.sv */
`timescale 1ns / 100ps
// Checker for the maze navigation step: tracks robot state, computes each result, compares.
module lmns_checker
  import lmns_pkg::*;
#(
  parameter int PATH_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // fields from bit 0: sensors[3:0], path_entry[5:4], zero fill
  input  logic [7:0]  in_tdata,
  // fields from bit 0: req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // fields from bit 0: pos_x[7:0], pos_y[15:8], heading[17:16], action[19:18],
  // situation[21:20], destination[22], path_length[30:23], path_overflow[31],
  // replay_exhausted[32], zero fill
  input  logic [39:0] out_tdata,
  output int          errors,
  output int          pending
);

  // Last member sits in bit 0, so out_tdata[32:0] maps straight onto this.
  typedef struct packed {
    logic       exhausted;
    logic       overflow;
    logic [7:0] length;
    logic       dest;
    logic [1:0] situation;
    logic [1:0] action;
    logic [1:0] heading;
    logic [7:0] y;
    logic [7:0] x;
  } nav_move_t;

  logic       discover;
  logic [7:0] home_x;
  logic [7:0] home_y;
  logic [1:0] home_facing;

  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [1:0]  facing;
  logic [1:0]  route [PATH_DEPTH];
  int unsigned route_len;
  int unsigned replay_pos;
  logic        route_overflow;

  nav_move_t due_moves[$];

  function automatic logic [1:0] rotated(input logic [1:0] h, input logic [1:0] act);
    logic [1:0] r;
    r = h;
    case (act)
      ACT_ABOUT: r = h ^ 2'd1;
      ACT_LEFT: begin
        case (h)
          DIR_UP:   r = DIR_LEFT;
          DIR_DOWN: r = DIR_RIGHT;
          DIR_LEFT: r = DIR_DOWN;
          default:  r = DIR_UP;
        endcase
      end
      ACT_RIGHT: begin
        case (h)
          DIR_UP:   r = DIR_RIGHT;
          DIR_DOWN: r = DIR_LEFT;
          DIR_LEFT: r = DIR_UP;
          default:  r = DIR_DOWN;
        endcase
      end
      default: r = h;
    endcase
    return r;
  endfunction

  // Drop the entry and flag overflow once the store is full.
  task automatic record_turn(input logic [1:0] code);
    if (route_len < PATH_DEPTH) begin
      route[route_len] = code;
      route_len++;
    end else begin
      route_overflow = 1'b1;
    end
  endtask

  task automatic take_step(input logic [1:0] req, input logic [3:0] sns,
                           input logic [1:0] ent, output nav_move_t mv);
    int active;
    active = sns[0] + sns[1] + sns[2] + sns[3];
    mv = '0;
    if (req == REQ_STEP) begin
      mv.dest = (active == 4);
      if (active >= 3) begin
        mv.situation = SIT_CROSS;
        if (discover) begin
          // left hand rule: left, else straight, else right
          if (sns[SNS_LEFT])       mv.action = ACT_LEFT;
          else if (sns[SNS_AHEAD]) mv.action = ACT_NONE;
          else                     mv.action = ACT_RIGHT;
          record_turn(mv.action);
        end else if (replay_pos < route_len) begin
          mv.action = route[replay_pos];
          replay_pos++;
        end else begin
          mv.action    = ACT_NONE;
          mv.exhausted = 1'b1;
        end
      end else if (sns[SNS_BEHIND] && !sns[SNS_AHEAD] && (sns[SNS_LEFT] || sns[SNS_RIGHT])) begin
        mv.situation = SIT_TURN;
        mv.action    = sns[SNS_LEFT] ? ACT_LEFT : ACT_RIGHT;
      end else if (sns == 4'b0010) begin
        mv.situation = SIT_DEAD;
        mv.action    = ACT_ABOUT;
        if (discover) record_turn(ACT_ABOUT);
      end
      facing = rotated(facing, mv.action);
      case (facing)
        DIR_UP:   pos_y = pos_y - 8'd1;
        DIR_DOWN: pos_y = pos_y + 8'd1;
        DIR_LEFT: pos_x = pos_x - 8'd1;
        default:  pos_x = pos_x + 8'd1;
      endcase
    end else if (req == REQ_APPEND) begin
      record_turn(ent);
    end else if (req == REQ_RESTART) begin
      pos_x      = home_x;
      pos_y      = home_y;
      facing     = home_facing;
      replay_pos = 0;
      if (discover) begin
        route_len      = 0;
        route_overflow = 1'b0;
      end
    end
    mv.x        = pos_x;
    mv.y        = pos_y;
    mv.heading  = facing;
    mv.length   = route_len[7:0];
    mv.overflow = route_overflow;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    nav_move_t mv;
    nav_move_t got;
    if (!rst_n) begin
      discover       = 1'b1;
      home_x         = 8'd0;
      home_y         = 8'd0;
      home_facing    = DIR_RIGHT;
      pos_x          = 8'd0;
      pos_y          = 8'd0;
      facing         = DIR_RIGHT;
      route_len      = 0;
      replay_pos     = 0;
      route_overflow = 1'b0;
      errors         = 0;
      due_moves.delete();
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_step(in_tuser, in_tdata[3:0], in_tdata[5:4], mv);
        due_moves.push_back(mv);
      end
      if (out_tvalid && out_tready) begin
        got = nav_move_t'(out_tdata[32:0]);
        if (due_moves.size() == 0) begin
          $error("result transfer with nothing outstanding: %h", out_tdata);
          errors++;
        end else begin
          mv = due_moves.pop_front();
          check_field("pos_x", mv.x, got.x);
          check_field("pos_y", mv.y, got.y);
          check_field("heading", mv.heading, got.heading);
          check_field("action", mv.action, got.action);
          check_field("situation", mv.situation, got.situation);
          check_field("destination", mv.dest, got.dest);
          check_field("path_length", mv.length, got.length);
          check_field("path_overflow", mv.overflow, got.overflow);
          check_field("replay_exhausted", mv.exhausted, got.exhausted);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:    discover    = cfg_data[0];
          CFG_START_X: home_x      = cfg_data;
          CFG_START_Y: home_y      = cfg_data;
          CFG_FACING:  home_facing = cfg_data[1:0];
          default: ;
        endcase
      end
      pending <= due_moves.size();
    end
  end

endmodule

/* verif/tb_line_maze_navigation_step.sv */
`timescale 1ns / 100ps
// Testbench top: drives requests, settings and result backpressure, and reports the verdict.
module tb_line_maze_navigation_step;
  import lmns_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // fields from bit 0: sensors[3:0], path_entry[5:4], zero fill
  logic [7:0]  in_tdata = 8'd0;
  // fields from bit 0: req_type[1:0]
  logic [1:0]  in_tuser = REQ_STEP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // fields from bit 0: pos_x, pos_y, heading, action, situation, destination,
  // path_length, path_overflow, replay_exhausted, zero fill
  logic [39:0] out_tdata;

  int errors;
  int pending;
  int quiet_cycles = 0;
  bit calm = 1'b0;   // set during the stretch where neither side idles

  line_maze_navigation_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lmns_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver side: stall at random about 35 percent of the time, never while calm.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_maze_navigation_step test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, idling first at random, and hold it until the transfer.
  // Valid is never dropped and re-raised in one step: an idle cycle drives it
  // low, otherwise it simply stays high for the next request.
  task automatic send_req(input logic [1:0] req, input logic [3:0] sns,
                          input logic [1:0] ent);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, ent, sns};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait until every result has come back, then let the pipeline go quiet.
  // The checker's count is registered, so it lags the transfers it counts.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers in turn, mode first and facing last; only called while idle.
  task automatic write_settings(input bit mode, input logic [7:0] sx,
                                input logic [7:0] sy, input logic [1:0] face);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {7'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_START_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= CFG_START_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= CFG_FACING;
    cfg_data  <= {6'd0, face};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sensor patterns weighted toward the interesting spots: junctions (one
  // random sensor dropped from all four, or none), turns and dead ends
  // (behind set, ahead clear), and plain uniform noise.
  function automatic logic [3:0] pick_sensors(input int crossing_pct);
    int r;
    r = $urandom_range(99);
    if (r < crossing_pct)
      return 4'hF & ~(4'b0001 << $urandom_range(4));
    else if (r < crossing_pct + 20)
      return {$urandom_range(1) == 1, $urandom_range(1) == 1, 1'b1, 1'b0};
    else
      return 4'($urandom_range(15));
  endfunction

  // One random phase. Discovery runs mostly steps so the store fills and,
  // with no restarts, overflows; replay runs lean on junctions so the store
  // gets used up and the robot ends up going straight on exhausted replay.
  task automatic run_phase(input int count, input bit discovering, input int restart_pct);
    int r;
    send_req(REQ_RESTART, 4'($urandom_range(15)), 2'($urandom_range(3)));
    for (int n = 1; n < count; n++) begin
      r = $urandom_range(99);
      if (r < restart_pct)
        send_req(REQ_RESTART, 4'($urandom_range(15)), 2'($urandom_range(3)));
      else if (r < restart_pct + 3)
        send_req(REQ_UNUSED, 4'($urandom_range(15)), 2'($urandom_range(3)));
      else if (r < restart_pct + 11)
        send_req(REQ_APPEND, 4'($urandom_range(15)), 2'($urandom_range(3)));
      else
        send_req(REQ_STEP, pick_sensors(discovering ? 30 : 60), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    bit          discovering;
    logic [7:0]  sx;
    logic [7:0]  sy;
    int          len;
    int          restart_pct;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (discovery, start 0,0 facing right):
    // every sensor pattern, covering plain line, every junction choice,
    // turns both ways, the dead end and the all-four destination.
    for (int s = 0; s < 16; s++) send_req(REQ_STEP, s[3:0], 2'($urandom_range(3)));
    // Append each entry code, then an unused request that must change nothing.
    for (int e = 0; e < 4; e++) send_req(REQ_APPEND, 4'($urandom_range(15)), e[1:0]);
    send_req(REQ_UNUSED, 4'hF, 2'd3);
    drain();

    // Replay from the recorded store: the first entry is the dead end's
    // about-turn, so a replayed junction turns the robot around.
    write_settings(1'b0, 8'd255, 8'd0, DIR_UP);
    send_req(REQ_RESTART, 4'h0, 2'd0);
    send_req(REQ_STEP, 4'hF, 2'd0);
    send_req(REQ_STEP, 4'h7, 2'd0);   // heading right from column 255 wraps to 0
    send_req(REQ_STEP, 4'h0, 2'd0);
    drain();

    // Random phases alternate discovery and replay, sweeping the start
    // point between its extremes and every facing.
    for (int p = 0; p < 12; p++) begin
      discovering = (p % 2 == 0);
      case (p % 3)
        0:       sx = 8'd0;
        1:       sx = 8'd255;
        default: sx = 8'($urandom_range(255));
      endcase
      case ((p / 3) % 3)
        0:       sy = 8'd255;
        1:       sy = 8'd0;
        default: sy = 8'($urandom_range(255));
      endcase
      // Two long discovery phases without restarts push the store past full.
      len         = (p == 4 || p == 10) ? 320 : 110;
      restart_pct = (p == 4 || p == 10) ? 0 : 3;
      calm        = (p == 6 || p == 7);
      write_settings(discovering, sx, sy, p[1:0]);
      run_phase(len, discovering, restart_pct);
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("line_maze_navigation_step test passed");
    end else begin
      $display("line_maze_navigation_step test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lmns_pkg.sv
rtl/core/line_maze_navigation_step.sv
verif/lmns_checker.sv
verif/tb_line_maze_navigation_step.sv
